// ===== rtl/sat_pkg.sv =====
// Package for the sorted alarm timer queue: defaults, result kind codes,
// operation codes and the sequencer state type. No dependencies.
package sat_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_WIDTH_DEF   = 8;
   localparam int MAX_FIRE        = 16;
   localparam int TAG_PORT_W      = 8;
   localparam int DELAY_W         = 16;
   localparam int TIME_W          = 32;

   localparam logic       OP_TICK = 1'b0;
   localparam logic       OP_ADD  = 1'b1;

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_FIRED    = 2'd1;
   localparam logic [1:0] KIND_REJECTED = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_ZERO_ACK,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE_NEW,
      ST_FINAL
   } state_type;

endpackage

// ===== rtl/sorted_alarm_timer_queue_top.sv =====
// Sorted alarm timer queue: circular entry store in expiry order, one sequencer.
// A tick fires due alarms from the head until none is due, the list empties or MAX_FIRE alarms
// fired; an add searches for its slot, shifts the later entries up and writes the new one; a zero
// delay is acknowledged and then fired; a full table is rejected. A new word is taken only while
// the sequencer is idle; a waiting result in the output register stalls the sequencer.
// Synchronous reset clears time, count and control; no clearing pass. Needs sat_pkg, sat_entry_ram.
module sorted_alarm_timer_queue_top
   import sat_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [DELAY_W-1:0]    req_delay_seconds,
   input  logic [TAG_PORT_W-1:0] req_alarm_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_result_kind,
   output logic [TAG_PORT_W-1:0] rsp_fired_tag,
   output logic [DELAY_W-1:0]    rsp_fired_delay,
   output logic                  rsp_last_result
);

   localparam int IW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int FW    = $clog2(MAX_FIRE + 1);
   localparam int EW    = TIME_W + DELAY_W + TAG_WIDTH;
   localparam int KEEPW = (TAG_WIDTH < TAG_PORT_W) ? TAG_WIDTH : TAG_PORT_W;

   function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] l);
      logic [CW:0] s;
      begin
         s = (CW+1)'(h) + (CW+1)'(l);
         if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
         end
         return s[IW-1:0];
      end
   endfunction

   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [IW-1:0]         head_ff, head_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [FW-1:0]         fired_ff, fired_in;
   logic                  cand_valid_ff, cand_valid_in;
   logic [1:0]            cand_kind_ff, cand_kind_in;
   logic [TAG_WIDTH-1:0]  cand_tag_ff, cand_tag_in;
   logic [DELAY_W-1:0]    cand_delay_ff, cand_delay_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic [TAG_PORT_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic [DELAY_W-1:0]    rsp_delay_ff, rsp_delay_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  wr_en, rd_en;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic [EW-1:0]         wr_data, rd_data;

   logic                  req_take, out_free, head_due, srch_before;
   logic [TIME_W-1:0]     rd_expiry, rd_offset;
   logic [DELAY_W-1:0]    rd_delay;
   logic [TAG_WIDTH-1:0]  rd_tag;
   logic                  fire_stop;

   sat_entry_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign rd_expiry   = rd_data[EW-1 -: TIME_W];
   assign rd_delay    = rd_data[TAG_WIDTH + DELAY_W - 1 -: DELAY_W];
   assign rd_tag      = rd_data[TAG_WIDTH-1:0];
   assign rd_offset   = rd_expiry - now_ff;
   // wrap-safe: due when signed offset <= 0
   assign head_due    = (rd_offset == '0) || rd_offset[TIME_W-1];
   assign srch_before = rd_offset < TIME_W'(cand_delay_ff);
   assign fire_stop   = (count_ff == '0) || (fired_ff == FW'(MAX_FIRE));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_operation == OP_TICK) begin
                  state_in = ST_TICK_RD;
               end else if (req_delay_seconds == '0) begin
                  state_in = ST_ZERO_ACK;
               end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_TICK_RD: begin
            if (fire_stop) begin
               state_in = cand_valid_ff ? ST_FINAL : ST_IDLE;
            end else begin
               state_in = ST_TICK_CHK;
            end
         end
         ST_TICK_CHK: begin
            if (!head_due) begin
               state_in = cand_valid_ff ? ST_FINAL : ST_IDLE;
            end else if (!cand_valid_ff || out_free) begin
               state_in = ST_TICK_RD;
            end
         end
         ST_ZERO_ACK: begin
            if (out_free) begin
               state_in = ST_FINAL;
            end
         end
         ST_SRCH_RD: begin
            state_in = (idx_ff == count_ff) ? ST_SHIFT_RD : ST_SRCH_CHK;
         end
         ST_SRCH_CHK: begin
            state_in = srch_before ? ST_SRCH_RD : ST_SHIFT_RD;
         end
         ST_SHIFT_RD: begin
            state_in = (idx_ff == pos_ff) ? ST_WRITE_NEW : ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            state_in = ST_SHIFT_RD;
         end
         ST_WRITE_NEW: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      now_in        = now_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      fired_in      = fired_ff;
      cand_valid_in = cand_valid_ff;
      cand_kind_in  = cand_kind_ff;
      cand_tag_in   = cand_tag_ff;
      cand_delay_in = cand_delay_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_delay_in  = rsp_delay_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = phys(head_ff, idx_ff);
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = phys(head_ff, idx_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cand_valid_in = 1'b0;
               cand_tag_in   = TAG_WIDTH'(req_alarm_tag[KEEPW-1:0]);
               cand_delay_in = req_delay_seconds;
               idx_in        = '0;
               fired_in      = '0;
               if (req_operation == OP_TICK) begin
                  now_in = now_ff + TIME_W'(1);
               end else if (req_delay_seconds == '0) begin
                  cand_kind_in = KIND_FIRED;
               end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                  cand_kind_in = KIND_REJECTED;
               end else begin
                  cand_kind_in = KIND_ACCEPTED;
               end
            end
         end
         ST_TICK_RD: begin
            rd_en   = !fire_stop;
            rd_addr = head_ff;
         end
         ST_TICK_CHK: begin
            if (head_due && (!cand_valid_ff || out_free)) begin
               if (cand_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = cand_kind_ff;
                  rsp_tag_in   = TAG_PORT_W'(cand_tag_ff[KEEPW-1:0]);
                  rsp_delay_in = cand_delay_ff;
                  rsp_last_in  = 1'b0;
               end
               cand_valid_in = 1'b1;
               cand_kind_in  = KIND_FIRED;
               cand_tag_in   = rd_tag;
               cand_delay_in = rd_delay;
               head_in       = (head_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IW'(1);
               count_in      = count_ff - CW'(1);
               fired_in      = fired_ff + FW'(1);
            end
         end
         ST_ZERO_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACCEPTED;
               rsp_tag_in   = TAG_PORT_W'(cand_tag_ff[KEEPW-1:0]);
               rsp_delay_in = cand_delay_ff;
               rsp_last_in  = 1'b0;
            end
         end
         ST_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               pos_in = idx_ff;
            end else begin
               rd_en = 1'b1;
            end
         end
         ST_SRCH_CHK: begin
            if (srch_before) begin
               idx_in = idx_ff + CW'(1);
            end else begin
               pos_in = idx_ff;
               idx_in = count_ff;
            end
         end
         ST_SHIFT_RD: begin
            rd_en   = (idx_ff != pos_ff);
            rd_addr = phys(head_ff, idx_ff - CW'(1));
         end
         ST_SHIFT_WR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff - CW'(1);
         end
         ST_WRITE_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = phys(head_ff, pos_ff);
            wr_data  = {now_ff + TIME_W'(cand_delay_ff), cand_delay_ff, cand_tag_ff};
            count_in = count_ff + CW'(1);
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = cand_kind_ff;
               rsp_tag_in    = TAG_PORT_W'(cand_tag_ff[KEEPW-1:0]);
               rsp_delay_in  = cand_delay_ff;
               rsp_last_in   = 1'b1;
               cand_valid_in = 1'b0;
            end
         end
         default: begin
            cand_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         count_ff      <= '0;
         head_ff       <= '0;
         cand_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         cand_valid_ff <= cand_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      fired_ff      <= fired_in;
      cand_kind_ff  <= cand_kind_in;
      cand_tag_ff   <= cand_tag_in;
      cand_delay_ff <= cand_delay_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_delay_ff  <= rsp_delay_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_fired_tag   = rsp_tag_ff;
   assign rsp_fired_delay = rsp_delay_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

// ===== rtl/sat_entry_ram.sv =====
// Alarm entry store: one write port, one read port with registered data.
// Depends on sat_pkg for default sizes.
module sat_entry_ram
   import sat_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF,
   parameter int WIDTH = TIME_W + DELAY_W + TAG_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_sorted_alarm_timer_queue_top.sv =====
// Testbench for sorted_alarm_timer_queue_top: a directed table of words, then random bursts,
// all checked word by word against an in-bench model of the sorted alarm list.
// Depends on sat_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb_sorted_alarm_timer_queue_top;
   import sat_pkg::*;

   typedef struct packed {
      logic [1:0]            kind;
      logic [TAG_PORT_W-1:0] tag;
      logic [DELAY_W-1:0]    dly;
      logic                  last;
   } alarm_word_type;

   typedef struct {
      logic                  op;
      logic [DELAY_W-1:0]    dly;
      logic [TAG_PORT_W-1:0] tag;
      int                    reps;
      logic [TAG_PORT_W-1:0] tag_step;
      bit                    typed;
      alarm_word_type        first;
   } script_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;
   typedef enum int {MIX_BALANCED, MIX_ADDS, MIX_TICKS} burst_mix_type;

   localparam int RANDOM_ITEMS = 185;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 4 * QUEUE_DEPTH_DEF + 36;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_operation = OP_TICK;
   logic [DELAY_W-1:0]    req_delay_seconds = '0;
   logic [TAG_PORT_W-1:0] req_alarm_tag = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_result_kind;
   logic [TAG_PORT_W-1:0] rsp_fired_tag;
   logic [DELAY_W-1:0]    rsp_fired_delay;
   logic                  rsp_last_result;

   bit             typed_on = 1'b0;
   alarm_word_type typed_first = '0;
   bit             hold_request = 1'b0;

   // alarm list model
   logic [TIME_W-1:0]     clock_now = '0;
   int                    slots_used = 0;
   logic [TIME_W-1:0]     slot_expiry [QUEUE_DEPTH_DEF];
   logic [DELAY_W-1:0]    slot_delay  [QUEUE_DEPTH_DEF];
   logic [TAG_PORT_W-1:0] slot_tag    [QUEUE_DEPTH_DEF];

   alarm_word_type fresh_words[$];
   alarm_word_type awaited_words[$];

   int fail_count = 0;
   int items_sent = 0;
   int adds_taken = 0;
   int ticks_taken = 0;
   int words_checked = 0;
   int fired_seen = 0;
   int rejects_seen = 0;

   script_row_type dir_script [9] = '{
      '{OP_TICK, 16'd0,     8'h00, 1,  8'h00, 1'b0, '0},
      '{OP_ADD,  16'd0,     8'hAB, 1,  8'h00, 1'b1, '{KIND_ACCEPTED, 8'hAB, 16'd0, 1'b0}},
      '{OP_ADD,  16'd1,     8'h01, 1,  8'h00, 1'b1, '{KIND_ACCEPTED, 8'h01, 16'd1, 1'b1}},
      '{OP_ADD,  16'd1,     8'h02, 1,  8'h00, 1'b1, '{KIND_ACCEPTED, 8'h02, 16'd1, 1'b1}},
      '{OP_TICK, 16'd0,     8'h5A, 1,  8'h00, 1'b0, '0},
      '{OP_ADD,  16'd2,     8'h00, 16, 8'h11, 1'b0, '0},
      '{OP_ADD,  16'hFFFF,  8'hFF, 1,  8'h00, 1'b1, '{KIND_REJECTED, 8'hFF, 16'hFFFF, 1'b1}},
      '{OP_ADD,  16'd0,     8'h3C, 1,  8'h00, 1'b1, '{KIND_ACCEPTED, 8'h3C, 16'd0, 1'b0}},
      '{OP_TICK, 16'hFFFF,  8'hFF, 2,  8'h00, 1'b0, '0}
   };

   sorted_alarm_timer_queue_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_delay_seconds (req_delay_seconds),
      .req_alarm_tag     (req_alarm_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_fired_tag     (rsp_fired_tag),
      .rsp_fired_delay   (rsp_fired_delay),
      .rsp_last_result   (rsp_last_result)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("** sorted_alarm_timer_queue_top: FAILED **");
      $finish;
   end

   task automatic apply_alarm_word(input logic op, input logic [DELAY_W-1:0] dly,
                                   input logic [TAG_PORT_W-1:0] tg);
      alarm_word_type w;
      int             pos;
      int             i;
      fresh_words.delete();
      if (op == OP_ADD) begin
         if (dly == '0) begin
            fresh_words.push_back('{KIND_ACCEPTED, tg, 16'd0, 1'b0});
            fresh_words.push_back('{KIND_FIRED, tg, 16'd0, 1'b0});
         end else if (slots_used >= QUEUE_DEPTH_DEF) begin
            fresh_words.push_back('{KIND_REJECTED, tg, dly, 1'b0});
         end else begin
            pos = 0;
            while (pos < slots_used && (slot_expiry[pos] - clock_now) < TIME_W'(dly))
               pos++;
            for (i = slots_used; i > pos; i--) begin
               slot_expiry[i] = slot_expiry[i-1];
               slot_delay[i]  = slot_delay[i-1];
               slot_tag[i]    = slot_tag[i-1];
            end
            slot_expiry[pos] = clock_now + TIME_W'(dly);
            slot_delay[pos]  = dly;
            slot_tag[pos]    = tg;
            slots_used++;
            fresh_words.push_back('{KIND_ACCEPTED, tg, dly, 1'b0});
         end
      end else begin
         clock_now = clock_now + TIME_W'(1);
         while (fresh_words.size() < MAX_FIRE && slots_used > 0 &&
                $signed(slot_expiry[0] - clock_now) <= 0) begin
            fresh_words.push_back('{KIND_FIRED, slot_tag[0], slot_delay[0], 1'b0});
            for (i = 1; i < slots_used; i++) begin
               slot_expiry[i-1] = slot_expiry[i];
               slot_delay[i-1]  = slot_delay[i];
               slot_tag[i-1]    = slot_tag[i];
            end
            slots_used--;
         end
      end
      if (fresh_words.size() > 0) begin
         w = fresh_words.pop_back();
         w.last = 1'b1;
         fresh_words.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      alarm_word_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               $error("unexpected word: kind %0d tag %0h delay %0d last %0b",
                      rsp_result_kind, rsp_fired_tag, rsp_fired_delay, rsp_last_result);
               fail_count++;
            end else begin
               w = awaited_words.pop_front();
               words_checked++;
               if (rsp_result_kind !== w.kind) begin
                  $error("rsp_result_kind: expected %0d, got %0d", w.kind, rsp_result_kind);
                  fail_count++;
               end
               if (rsp_fired_tag !== w.tag) begin
                  $error("rsp_fired_tag: expected %0h, got %0h", w.tag, rsp_fired_tag);
                  fail_count++;
               end
               if (rsp_fired_delay !== w.dly) begin
                  $error("rsp_fired_delay: expected %0d, got %0d", w.dly, rsp_fired_delay);
                  fail_count++;
               end
               if (rsp_last_result !== w.last) begin
                  $error("rsp_last_result: expected %0b, got %0b", w.last, rsp_last_result);
                  fail_count++;
               end
               if (w.kind == KIND_FIRED) fired_seen++;
               if (w.kind == KIND_REJECTED) rejects_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            apply_alarm_word(req_operation, req_delay_seconds, req_alarm_tag);
            if (typed_on && fresh_words.size() > 0) fresh_words[0] = typed_first;
            foreach (fresh_words[k]) awaited_words.push_back(fresh_words[k]);
            if (req_operation == OP_ADD) adds_taken++;
            else ticks_taken++;
         end
      end
   end

   // receiver: one long hold-off on request, otherwise a changing stall pattern
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             hold_left;
      int             phase;
      bit             hold_used;
      mode = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      phase = 0;
      hold_used = 1'b0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
               default:     rsp_stall <= ((phase % 5) < 2);
            endcase
         end
      end
   end

   task automatic offer_word(input logic op, input logic [DELAY_W-1:0] dly,
                             input logic [TAG_PORT_W-1:0] tg, input bit typed,
                             input alarm_word_type first);
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_delay_seconds <= dly;
      req_alarm_tag     <= tg;
      typed_on          <= typed;
      typed_first       <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   initial begin
      burst_mix_type         mix;
      int                    burst_len;
      int                    gap;
      int                    add_pct;
      int                    pick;
      logic                  op;
      logic [DELAY_W-1:0]    dly;
      logic [TAG_PORT_W-1:0] tg;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_script[r])
         for (int k = 0; k < dir_script[r].reps; k++)
            offer_word(dir_script[r].op, dir_script[r].dly,
                       dir_script[r].tag + TAG_PORT_W'(k) * dir_script[r].tag_step,
                       dir_script[r].typed, dir_script[r].first);

      hold_request <= 1'b1;
      while (items_sent < 25 + RANDOM_ITEMS) begin
         mix = burst_mix_type'($urandom_range(0, 2));
         add_pct = (mix == MIX_ADDS) ? 85 : (mix == MIX_TICKS) ? 20 : 55;
         burst_len = $urandom_range(1, 12);
         for (int b = 0; b < burst_len; b++) begin
            op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TICK;
            tg = TAG_PORT_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 8) dly = '0;
            else if (pick < 12) dly = DELAY_W'($urandom_range(0, 65535));
            else if (pick < 14) dly = '1;
            else dly = DELAY_W'($urandom_range(1, 24));
            offer_word(op, dly, tg, 1'b0, '0);
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      while (awaited_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d adds and %0d ticks; checked %0d words (%0d fired, %0d rejected).",
               adds_taken, ticks_taken, words_checked, fired_seen, rejects_seen);
      if (fail_count == 0)
         $display("** sorted_alarm_timer_queue_top: PASSED **");
      else
         $display("** sorted_alarm_timer_queue_top: FAILED **");
      $finish;
   end

endmodule
